@@ hw/rtl/log_record_protobuf_encoder_top_macros.svh @@
// Assertion macros for the log record encoder; they compile away when SYNTH is defined.
`ifndef LOG_RECORD_PROTOBUF_ENCODER_TOP_MACROS_SVH
`define LOG_RECORD_PROTOBUF_ENCODER_TOP_MACROS_SVH
`ifndef SYNTH
`define LRPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrpe assertion failed");
`define LRPE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrpe assertion failed");
`else
`define LRPE_ASSERT_IMP(label, ante, cons)
`define LRPE_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/lrpe_pkg.sv @@
// Shared constants, types and helper functions of the log record encoder.
package lrpe_pkg;

    localparam int TIME_W = 32;
    localparam int LEN_W  = 24;
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LENGTHS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DATA    = 2'd3;

    localparam logic [BYTE_W-1:0] TAG_RECORD = 8'h0A;
    localparam logic [BYTE_W-1:0] TAG_TIME   = 8'h08;
    localparam logic [BYTE_W-1:0] TAG_PAIR   = 8'h12;
    localparam logic [BYTE_W-1:0] TAG_KEY    = 8'h0A;
    localparam logic [BYTE_W-1:0] TAG_VALUE  = 8'h12;
    localparam logic [BYTE_W-1:0] VARINT_MORE = 8'h80;

    localparam logic [TIME_W-1:0] MIN_TIME_RESET = 32'd1263563523;
    localparam logic [TIME_W-1:0] TIME_FLOOR     = 32'h1000_0000;
    localparam logic [31:0]       EMPTY_SIZE     = 32'd6;

    localparam logic [2:0] VSEL_SIZE  = 3'd0;
    localparam logic [2:0] VSEL_TIME  = 3'd1;
    localparam logic [2:0] VSEL_CS    = 3'd2;
    localparam logic [2:0] VSEL_KEY   = 3'd3;
    localparam logic [2:0] VSEL_VALUE = 3'd4;

    typedef struct packed {
        logic              emit_const;
        logic [BYTE_W-1:0] const_byte;
        logic              emit_var;
        logic              emit_data;
        logic              emit_err;
        logic              mark_end;
        logic              load_var;
        logic [2:0]        var_sel;
        logic              begin_rec;
        logic              clear_rec;
        logic              store_len;
        logic              ram_rd;
        logic              latch_ram;
        logic              calc_cs;
        logic              calc_sum;
        logic              pidx_inc;
        logic              pidx_zero;
        logic              left_load_k;
        logic              left_load_v;
        logic              left_dec;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic var_last;
        logic cnt_bad;
        logic cnt_zero;
        logic len_bad;
        logic pidx_full;
        logic pidx_last;
        logic ovf;
        logic k_zero;
        logic v_zero;
        logic left_one;
        logic in_value;
    } status_t;

    // Number of bytes in the varint form of a value.
    function automatic logic [2:0] vsize(input logic [31:0] v);
        logic [2:0] n;
        if (v < 32'h80) n = 3'd1;
        else if (v < 32'h4000) n = 3'd2;
        else if (v < 32'h20_0000) n = 3'd3;
        else if (v < 32'h1000_0000) n = 3'd4;
        else n = 3'd5;
        return n;
    endfunction

endpackage

@@ hw/rtl/lrpe_in_if.sv @@
// Input channel of the log record encoder.
interface lrpe_in_if;
    logic                            valid;
    logic                            ready;
    logic [lrpe_pkg::MODE_W-1:0]     mode;
    logic [lrpe_pkg::TIME_W-1:0]     log_time;
    logic [lrpe_pkg::CNT_W-1:0]      pair_total;
    logic [lrpe_pkg::LEN_W-1:0]      key_length;
    logic [lrpe_pkg::LEN_W-1:0]      value_length;
    logic [lrpe_pkg::BYTE_W-1:0]     data_byte;

    modport source (output valid, mode, log_time, pair_total, key_length, value_length,
                    data_byte, input ready);
    modport sink (input valid, mode, log_time, pair_total, key_length, value_length,
                  data_byte, output ready);
endinterface

@@ hw/rtl/lrpe_out_if.sv @@
// Output channel of the log record encoder.
interface lrpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [lrpe_pkg::BYTE_W-1:0] out_byte;
    logic                        byte_valid;
    logic                        record_end;
    logic                        error_code;

    modport source (output valid, out_byte, byte_valid, record_end, error_code, input ready);
    modport sink (input valid, out_byte, byte_valid, record_end, error_code, output ready);
endinterface

@@ hw/rtl/log_record_protobuf_encoder_top.sv @@
// Top level of the log record encoder: controller, datapath and checks.
//
//  channel  | direction | carries
//  ---------+-----------+--------------------------------------------------
//  in_ch    | sink      | begin, pair-length, pair-start and data-byte items
//  out_ch   | source    | one encoded byte or one error result per transfer
//  cfg      | write     | min_log_time clamp register
//
// A data byte item goes straight to the output register, so key and value bytes
// stream at one item per cycle while the output side keeps taking them; the byte
// that closes a key adds the value header (up to five more bytes). Each header
// goes out one byte per cycle while the output takes the bytes. A begin item with
// no pairs goes straight to the record header. A pair-length item passes the
// size adder path (store, content-size add, sum); the one that completes the
// lengths emits the record header (up to twelve bytes). A pair-start item reads
// the table, latches and sizes the entry, then emits its header (up to twelve).
// The single output register sets every emission rate.
// Reset clears all control state; the length tables need no clearing since an
// entry is always written earlier in the same record than it is read.
// Any stall on the output blocks input and holds the controller in its emitting and error states.
module log_record_protobuf_encoder_top #(
    parameter int MAX_PAIRS   = 64,
    parameter int LENGTH_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lrpe_pkg::TIME_W-1:0] cfg_data,
    lrpe_in_if.sink                     in_ch,
    lrpe_out_if.source                  out_ch
);
    `include "log_record_protobuf_encoder_top_macros.svh"

    lrpe_pkg::cmd_t    cmd;
    lrpe_pkg::status_t st;

    // The controller decides what happens to each item; the datapath holds
    // the record state and the output register.
    lrpe_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_mode(in_ch.mode),
        .in_ready(in_ch.ready), .st(st), .cmd(cmd)
    );

    lrpe_dp #(.MAX_PAIRS(MAX_PAIRS), .LENGTH_BITS(LENGTH_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .log_time(in_ch.log_time), .pair_total(in_ch.pair_total),
        .key_length(in_ch.key_length), .value_length(in_ch.value_length),
        .data_byte(in_ch.data_byte), .cmd(cmd), .st(st),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_byte(out_ch.out_byte), .byte_valid(out_ch.byte_valid),
        .record_end(out_ch.record_end), .error_code(out_ch.error_code)
    );

    // An error result never carries a byte and always closes the record.
    `LRPE_ASSERT_IMP(a_err_shape, out_ch.valid && out_ch.error_code, !out_ch.byte_valid && out_ch.record_end)
    // The block only takes an item when the output register can take a result.
    `LRPE_ASSERT_IMP(a_in_room, in_ch.ready, !out_ch.valid || out_ch.ready)
    // At most one source writes the output register in a cycle.
    `LRPE_ASSERT_IMP(a_one_src, 1'b1, $onehot0({cmd.emit_const, cmd.emit_var, cmd.emit_data, cmd.emit_err}))
    // Every emission shows up on the output in the next cycle.
    `LRPE_ASSERT_NXT(a_emit_out, cmd.emit_const || cmd.emit_var || cmd.emit_data || cmd.emit_err, out_ch.valid)
endmodule

@@ hw/rtl/lrpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lrpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/lrpe_ctrl.sv @@
// Controller state machine that sequences item checks and byte emission.
module lrpe_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [lrpe_pkg::MODE_W-1:0] in_mode,
    output logic                        in_ready,
    input  lrpe_pkg::status_t           st,
    output lrpe_pkg::cmd_t              cmd
);
    localparam logic [3:0] S_WAIT = 4'd0;
    localparam logic [3:0] S_CS   = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_ERR  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_CSP  = 4'd5;
    localparam logic [3:0] S_H0   = 4'd6;
    localparam logic [3:0] S_H1   = 4'd7;
    localparam logic [3:0] S_H2   = 4'd8;
    localparam logic [3:0] S_H3   = 4'd9;
    localparam logic [3:0] S_P0   = 4'd10;
    localparam logic [3:0] S_P1   = 4'd11;
    localparam logic [3:0] S_P2   = 4'd12;
    localparam logic [3:0] S_P3   = 4'd13;
    localparam logic [3:0] S_V0   = 4'd14;
    localparam logic [3:0] S_V1   = 4'd15;

    logic [3:0]                  state_reg, state_next;
    logic [lrpe_pkg::MODE_W-1:0] phase_reg, phase_next;
    logic                        hdr_end_reg, hdr_end_next;
    logic                        fire;

    assign in_ready = (state_reg == S_WAIT) && st.out_free;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        phase_next   = phase_reg;
        hdr_end_next = hdr_end_reg;
        case (state_reg)
            S_WAIT:
            begin
                if (fire)
                begin
                    if (in_mode != phase_reg)
                    begin
                        cmd.emit_err  = 1'b1;
                        cmd.clear_rec = 1'b1;
                        phase_next    = lrpe_pkg::MODE_BEGIN;
                    end
                    else
                    begin
                        case (in_mode)
                            lrpe_pkg::MODE_BEGIN:
                            begin
                                if (st.cnt_bad)
                                begin
                                    cmd.emit_err  = 1'b1;
                                    cmd.clear_rec = 1'b1;
                                end
                                else
                                begin
                                    cmd.begin_rec = 1'b1;
                                    if (st.cnt_zero)
                                    begin
                                        hdr_end_next = 1'b1;
                                        state_next   = S_H0;
                                    end
                                    else
                                    begin
                                        phase_next = lrpe_pkg::MODE_LENGTHS;
                                    end
                                end
                            end
                            lrpe_pkg::MODE_LENGTHS:
                            begin
                                if (st.len_bad || st.pidx_full)
                                begin
                                    cmd.emit_err  = 1'b1;
                                    cmd.clear_rec = 1'b1;
                                    phase_next    = lrpe_pkg::MODE_BEGIN;
                                end
                                else
                                begin
                                    cmd.store_len = 1'b1;
                                    state_next    = S_CS;
                                end
                            end
                            lrpe_pkg::MODE_START:
                            begin
                                if (st.pidx_full)
                                begin
                                    cmd.emit_err  = 1'b1;
                                    cmd.clear_rec = 1'b1;
                                    phase_next    = lrpe_pkg::MODE_BEGIN;
                                end
                                else
                                begin
                                    cmd.ram_rd = 1'b1;
                                    state_next = S_RD;
                                end
                            end
                            default:
                            begin
                                cmd.emit_data = 1'b1;
                                cmd.left_dec  = 1'b1;
                                if (st.left_one)
                                begin
                                    if (!st.in_value)
                                    begin
                                        state_next = S_V0;
                                    end
                                    else
                                    begin
                                        cmd.pidx_inc = 1'b1;
                                        cmd.mark_end = st.pidx_last;
                                        if (st.pidx_last)
                                        begin
                                            cmd.clear_rec = 1'b1;
                                            phase_next    = lrpe_pkg::MODE_BEGIN;
                                        end
                                        else
                                        begin
                                            phase_next = lrpe_pkg::MODE_START;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_CS:
            begin
                cmd.calc_cs = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                if (st.ovf)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.calc_sum = 1'b1;
                    cmd.pidx_inc = 1'b1;
                    if (st.pidx_last)
                    begin
                        hdr_end_next = 1'b0;
                        state_next   = S_H0;
                    end
                    else
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.emit_err  = 1'b1;
                    cmd.clear_rec = 1'b1;
                    phase_next    = lrpe_pkg::MODE_BEGIN;
                    state_next    = S_WAIT;
                end
            end
            S_RD:
            begin
                cmd.latch_ram = 1'b1;
                state_next    = S_CSP;
            end
            S_CSP:
            begin
                cmd.calc_cs = 1'b1;
                state_next  = S_P0;
            end
            S_H0, S_H2, S_P0, S_P2, S_V0:
            begin
                if (st.out_free)
                begin
                    cmd.emit_const = 1'b1;
                    cmd.load_var   = 1'b1;
                    case (state_reg)
                        S_H0:
                        begin
                            cmd.const_byte = lrpe_pkg::TAG_RECORD;
                            cmd.var_sel    = lrpe_pkg::VSEL_SIZE;
                            state_next     = S_H1;
                        end
                        S_H2:
                        begin
                            cmd.const_byte = lrpe_pkg::TAG_TIME;
                            cmd.var_sel    = lrpe_pkg::VSEL_TIME;
                            state_next     = S_H3;
                        end
                        S_P0:
                        begin
                            cmd.const_byte = lrpe_pkg::TAG_PAIR;
                            cmd.var_sel    = lrpe_pkg::VSEL_CS;
                            state_next     = S_P1;
                        end
                        S_P2:
                        begin
                            cmd.const_byte = lrpe_pkg::TAG_KEY;
                            cmd.var_sel    = lrpe_pkg::VSEL_KEY;
                            state_next     = S_P3;
                        end
                        default:
                        begin
                            cmd.const_byte = lrpe_pkg::TAG_VALUE;
                            cmd.var_sel    = lrpe_pkg::VSEL_VALUE;
                            state_next     = S_V1;
                        end
                    endcase
                end
            end
            S_H1, S_P1:
            begin
                if (st.out_free)
                begin
                    cmd.emit_var = 1'b1;
                    if (st.var_last)
                    begin
                        state_next = (state_reg == S_H1) ? S_H2 : S_P2;
                    end
                end
            end
            S_H3:
            begin
                if (st.out_free)
                begin
                    cmd.emit_var = 1'b1;
                    cmd.mark_end = hdr_end_reg && st.var_last;
                    if (st.var_last)
                    begin
                        state_next = S_WAIT;
                        if (hdr_end_reg)
                        begin
                            cmd.clear_rec = 1'b1;
                            phase_next    = lrpe_pkg::MODE_BEGIN;
                        end
                        else
                        begin
                            cmd.pidx_zero = 1'b1;
                            phase_next    = lrpe_pkg::MODE_START;
                        end
                    end
                end
            end
            S_P3:
            begin
                if (st.out_free)
                begin
                    cmd.emit_var = 1'b1;
                    if (st.var_last)
                    begin
                        if (!st.k_zero)
                        begin
                            cmd.left_load_k = 1'b1;
                            phase_next      = lrpe_pkg::MODE_DATA;
                            state_next      = S_WAIT;
                        end
                        else
                        begin
                            state_next = S_V0;
                        end
                    end
                end
            end
            default:
            begin
                if (st.out_free)
                begin
                    cmd.emit_var = 1'b1;
                    cmd.mark_end = st.var_last && st.v_zero && st.pidx_last;
                    if (st.var_last)
                    begin
                        state_next = S_WAIT;
                        if (!st.v_zero)
                        begin
                            cmd.left_load_v = 1'b1;
                            phase_next      = lrpe_pkg::MODE_DATA;
                        end
                        else
                        begin
                            cmd.pidx_inc = 1'b1;
                            if (st.pidx_last)
                            begin
                                cmd.clear_rec = 1'b1;
                                phase_next    = lrpe_pkg::MODE_BEGIN;
                            end
                            else
                            begin
                                phase_next = lrpe_pkg::MODE_START;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_WAIT;
            phase_reg   <= lrpe_pkg::MODE_BEGIN;
            hdr_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            hdr_end_reg <= hdr_end_next;
        end
    end
endmodule

@@ hw/rtl/lrpe_dp.sv @@
// Datapath: record counters, length tables, size arithmetic, varint shifter, output register.
module lrpe_dp #(
    parameter int MAX_PAIRS   = 64,
    parameter int LENGTH_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lrpe_pkg::TIME_W-1:0] cfg_data,
    input  logic [lrpe_pkg::TIME_W-1:0] log_time,
    input  logic [lrpe_pkg::CNT_W-1:0]  pair_total,
    input  logic [lrpe_pkg::LEN_W-1:0]  key_length,
    input  logic [lrpe_pkg::LEN_W-1:0]  value_length,
    input  logic [lrpe_pkg::BYTE_W-1:0] data_byte,
    input  lrpe_pkg::cmd_t              cmd,
    output lrpe_pkg::status_t           st,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lrpe_pkg::BYTE_W-1:0] out_byte,
    output logic                        byte_valid,
    output logic                        record_end,
    output logic                        error_code
);
    localparam int KW = (LENGTH_BITS < lrpe_pkg::LEN_W) ? LENGTH_BITS : lrpe_pkg::LEN_W;
    localparam int PW = $clog2(MAX_PAIRS + 1);
    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    logic [31:0]                 min_time_reg, time_reg, size_reg, time_next, size_next;
    logic [lrpe_pkg::CNT_W-1:0]  expected_reg, expected_next;
    logic [PW-1:0]               pidx_reg, pidx_next;
    logic [KW-1:0]               left_reg, left_next;
    logic                        inval_reg, inval_next;
    logic                        out_valid_reg, out_valid_next;
    logic [KW-1:0]               k_reg, v_reg, k_ram, v_ram;
    logic [31:0]                 cs_reg, var_reg, var_sel_val, floor_val;
    logic [32:0]                 sum_val;
    logic [lrpe_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        byte_valid_reg, record_end_reg, error_code_reg;
    logic [AW-1:0]               addr;

    assign addr = pidx_reg[AW-1:0];

    lrpe_ram #(.WIDTH(KW), .DEPTH(MAX_PAIRS)) u_key_ram (
        .clk(clk), .we(cmd.store_len), .waddr(addr), .wdata(key_length[KW-1:0]),
        .re(cmd.ram_rd), .raddr(addr), .rdata(k_ram)
    );

    lrpe_ram #(.WIDTH(KW), .DEPTH(MAX_PAIRS)) u_value_ram (
        .clk(clk), .we(cmd.store_len), .waddr(addr), .wdata(value_length[KW-1:0]),
        .re(cmd.ram_rd), .raddr(addr), .rdata(v_ram)
    );

    assign floor_val = (min_time_reg < lrpe_pkg::TIME_FLOOR) ? lrpe_pkg::TIME_FLOOR
                                                             : min_time_reg;
    assign sum_val = {1'b0, size_reg} + {1'b0, cs_reg} + 33'd1
                   + 33'(lrpe_pkg::vsize(cs_reg));

    always_comb
    begin
        case (cmd.var_sel)
            lrpe_pkg::VSEL_SIZE: var_sel_val = size_reg;
            lrpe_pkg::VSEL_TIME: var_sel_val = time_reg;
            lrpe_pkg::VSEL_CS:   var_sel_val = cs_reg;
            lrpe_pkg::VSEL_KEY:  var_sel_val = 32'(k_reg);
            default:             var_sel_val = 32'(v_reg);
        endcase
    end

    always_comb
    begin
        st.out_free  = !out_valid_reg || out_ready;
        st.var_last  = (var_reg < 32'h80);
        st.cnt_bad   = (32'(pair_total) > 32'(MAX_PAIRS));
        st.cnt_zero  = (pair_total == '0);
        st.len_bad   = ((key_length >> LENGTH_BITS) != '0)
                    || ((value_length >> LENGTH_BITS) != '0);
        st.pidx_full = (32'(pidx_reg) >= 32'(MAX_PAIRS));
        st.pidx_last = ((32'(pidx_reg) + 32'd1) >= 32'(expected_reg));
        st.ovf       = sum_val[32];
        st.k_zero    = (k_reg == '0);
        st.v_zero    = (v_reg == '0);
        st.left_one  = (left_reg == KW'(1));
        st.in_value  = inval_reg;
    end

    always_comb
    begin
        time_next      = time_reg;
        size_next      = size_reg;
        expected_next  = expected_reg;
        pidx_next      = pidx_reg;
        left_next      = left_reg;
        inval_next     = inval_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit_const || cmd.emit_var || cmd.emit_data || cmd.emit_err)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.calc_sum)
        begin
            size_next = sum_val[31:0];
        end
        if (cmd.pidx_inc)
        begin
            pidx_next = pidx_reg + PW'(1);
        end
        if (cmd.pidx_zero)
        begin
            pidx_next = '0;
        end
        if (cmd.left_dec)
        begin
            left_next = left_reg - KW'(1);
        end
        if (cmd.left_load_k)
        begin
            left_next  = k_reg;
            inval_next = 1'b0;
        end
        if (cmd.left_load_v)
        begin
            left_next  = v_reg;
            inval_next = 1'b1;
        end
        if (cmd.clear_rec || cmd.begin_rec)
        begin
            size_next     = lrpe_pkg::EMPTY_SIZE;
            expected_next = '0;
            pidx_next     = '0;
            left_next     = '0;
            inval_next    = 1'b0;
        end
        if (cmd.begin_rec)
        begin
            time_next     = (log_time < floor_val) ? floor_val : log_time;
            expected_next = pair_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg  <= lrpe_pkg::MIN_TIME_RESET;
            time_reg      <= '0;
            size_reg      <= lrpe_pkg::EMPTY_SIZE;
            expected_reg  <= '0;
            pidx_reg      <= '0;
            left_reg      <= '0;
            inval_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_time_reg <= cfg_data;
            end
            time_reg      <= time_next;
            size_reg      <= size_next;
            expected_reg  <= expected_next;
            pidx_reg      <= pidx_next;
            left_reg      <= left_next;
            inval_reg     <= inval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_len)
        begin
            k_reg <= key_length[KW-1:0];
            v_reg <= value_length[KW-1:0];
        end
        if (cmd.latch_ram)
        begin
            k_reg <= k_ram;
            v_reg <= v_ram;
        end
        if (cmd.calc_cs)
        begin
            cs_reg <= 32'(k_reg) + 32'(v_reg) + 32'(lrpe_pkg::vsize(32'(k_reg)))
                    + 32'(lrpe_pkg::vsize(32'(v_reg))) + 32'd2;
        end
        if (cmd.load_var)
        begin
            var_reg <= var_sel_val;
        end
        else if (cmd.emit_var)
        begin
            var_reg <= var_reg >> 7;
        end
        if (cmd.emit_const)
        begin
            out_byte_reg   <= cmd.const_byte;
            byte_valid_reg <= 1'b1;
            record_end_reg <= 1'b0;
            error_code_reg <= 1'b0;
        end
        else if (cmd.emit_var)
        begin
            out_byte_reg   <= st.var_last ? var_reg[7:0]
                                          : (lrpe_pkg::VARINT_MORE | {1'b0, var_reg[6:0]});
            byte_valid_reg <= 1'b1;
            record_end_reg <= cmd.mark_end;
            error_code_reg <= 1'b0;
        end
        else if (cmd.emit_data)
        begin
            out_byte_reg   <= data_byte;
            byte_valid_reg <= 1'b1;
            record_end_reg <= cmd.mark_end;
            error_code_reg <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_byte_reg   <= '0;
            byte_valid_reg <= 1'b0;
            record_end_reg <= 1'b1;
            error_code_reg <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign record_end = record_end_reg;
    assign error_code = error_code_reg;
endmodule
